// ----- sv/gcc_pkg.sv -----
// ============================================================================
// gcc_pkg: shared definitions for the graph connectivity checker
// Holds the store size, field widths, request codes, controller states and
// the one-hot to index encoder used by the traversal logic.
// ============================================================================
`default_nettype none

package gcc_pkg;

    // Store size and derived widths.
    localparam int MAX_NODES    = 64;
    localparam int NODE_IDX_W   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int COUNT_W      = $clog2(MAX_NODES + 1);

    // Fixed field widths of the request and result items.
    localparam int REQ_W        = 2;
    localparam int NODE_W       = 6;
    localparam int NODE_COUNT_W = 7;

    typedef logic [MAX_NODES-1:0] node_mask_t;

    // Request kinds.
    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR    = 2'd0,
        REQ_ADD_NODE = 2'd1,
        REQ_ADD_EDGE = 2'd2,
        REQ_QUERY    = 2'd3
    } req_type_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_NODE,
        ST_EDGE_RD_A,
        ST_EDGE_WR_A,
        ST_EDGE_RD_B,
        ST_EDGE_WR_B,
        ST_Q_INIT,
        ST_Q_PICK,
        ST_Q_EXP,
        ST_Q_FIN,
        ST_RESP
    } state_t;

    // Turns a one-hot node mask into the index of its set bit.
    function automatic logic [NODE_IDX_W-1:0] onehot_to_idx(input node_mask_t oh);
        logic [NODE_IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAX_NODES; i++) begin
            if (oh[i]) begin
                idx = idx | NODE_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ----- sv/gcc_ram.sv -----
// ============================================================================
// gcc_ram: generic single-port RAM
// One read or write per cycle, with registered read data that is valid in the cycle after its address.
// ============================================================================
`default_nettype none

module gcc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                                    aclk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                        wdata,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port share one address.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ----- sv/graph_connectivity_checker_core.sv -----
// ============================================================================
// graph_connectivity_checker_core: undirected graph store with connectivity query
// Keeps a symmetric adjacency bit matrix in a RAM, one row per node, and
// answers whether every node can be reached from node 0.
// ============================================================================
//
//  Channel | Direction | Handshake        | Payload
//  --------+-----------+------------------+-------------------------------------
//  s_      | in        | s_valid/s_ready  | s_req_type, s_pred_node, s_prey_node
//  m_      | out       | m_valid/m_ready  | m_status, m_connected, m_node_count
//
//  Steps per request: clear and add node each pass through their own working
//  state and the response state, add edge makes two read-modify-write passes
//  over the single RAM port or stops after the first read when an endpoint is
//  refused, and query picks each node reachable from node 0 in turn, reading
//  its row and merging it into the reached set. The result register loads as
//  the controller returns to idle, where the next request can be taken.
//  Reset and clear drop the row valid bits at once; there is no clearing pass.
//  A new request is taken while an earlier result still waits on m_ready; a
//  stalled result holds the controller in its response state.
//
`default_nettype none

module graph_connectivity_checker_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [gcc_pkg::REQ_W-1:0]        s_req_type,
    input  wire logic [gcc_pkg::NODE_W-1:0]       s_pred_node,
    input  wire logic [gcc_pkg::NODE_W-1:0]       s_prey_node,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_status,
    output logic                                  m_connected,
    output logic [gcc_pkg::NODE_COUNT_W-1:0]      m_node_count
);

    import gcc_pkg::*;

    // Controller and working registers.
    state_t                 state_reg, state_next;
    req_type_t              req_type_reg, req_type_next;
    logic [NODE_W-1:0]      pred_reg, pred_next;
    logic [NODE_W-1:0]      prey_reg, prey_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    node_mask_t             visited_reg, visited_next;
    node_mask_t             expanded_reg, expanded_next;
    node_mask_t             valid_reg, valid_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic                   status_reg, status_next;
    logic                   conn_reg, conn_next;

    // Result register.
    logic                   m_valid_reg, m_valid_next;
    logic                   m_status_reg, m_status_next;
    logic                   m_connected_reg, m_connected_next;
    logic [NODE_COUNT_W-1:0] m_node_count_reg, m_node_count_next;

    // RAM port.
    logic                   ram_we;
    logic [NODE_IDX_W-1:0]  ram_addr;
    node_mask_t             ram_wdata;
    node_mask_t             ram_rdata;

    // Derived datapath values.
    logic [NODE_IDX_W-1:0]  pred_idx;
    logic [NODE_IDX_W-1:0]  prey_idx;
    node_mask_t             pred_bit;
    node_mask_t             prey_bit;
    node_mask_t             row_data;
    node_mask_t             cnt_mask;
    node_mask_t             pend;
    node_mask_t             pick_oh;
    logic [NODE_IDX_W-1:0]  pick_idx;
    logic                   edge_ok;
    logic                   out_free;
    logic                   out_load;

    gcc_ram #(
        .WIDTH (MAX_NODES),
        .DEPTH (MAX_NODES)
    ) u_adj_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Index decoding, row masking and the lowest pending node.
    always_comb begin
        pred_idx = NODE_IDX_W'(pred_reg);
        prey_idx = NODE_IDX_W'(prey_reg);
        pred_bit = node_mask_t'(1) << pred_idx;
        prey_bit = node_mask_t'(1) << prey_idx;
        row_data = rd_valid_reg ? ram_rdata : '0;
        edge_ok  = (32'(pred_reg) < 32'(count_reg)) && (32'(prey_reg) < 32'(count_reg));
        for (int i = 0; i < MAX_NODES; i++) begin
            cnt_mask[i] = (COUNT_W'(i) < count_reg);
        end
        pend     = visited_reg & ~expanded_reg;
        pick_oh  = pend & (~pend + node_mask_t'(1));
        pick_idx = onehot_to_idx(pick_oh);
        out_free = !m_valid_reg || m_ready;
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (req_type_t'(s_req_type))
                        REQ_CLEAR:    state_next = ST_CLEAR;
                        REQ_ADD_NODE: state_next = ST_NODE;
                        REQ_ADD_EDGE: state_next = ST_EDGE_RD_A;
                        default:      state_next = ST_Q_INIT;
                    endcase
                end
            end
            ST_CLEAR:     state_next = ST_RESP;
            ST_NODE:      state_next = ST_RESP;
            ST_EDGE_RD_A: state_next = edge_ok ? ST_EDGE_WR_A : ST_RESP;
            ST_EDGE_WR_A: state_next = ST_EDGE_RD_B;
            ST_EDGE_RD_B: state_next = ST_EDGE_WR_B;
            ST_EDGE_WR_B: state_next = ST_RESP;
            ST_Q_INIT:    state_next = ST_Q_PICK;
            ST_Q_PICK:    state_next = (pend == '0) ? ST_Q_FIN : ST_Q_EXP;
            ST_Q_EXP:     state_next = ST_Q_PICK;
            ST_Q_FIN:     state_next = ST_RESP;
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Handshake and RAM port controls decoded from the state.
    always_comb begin
        s_ready   = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = pred_idx;
        ram_wdata = row_data | prey_bit;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:      s_ready = 1'b1;
            ST_EDGE_RD_A: ram_addr = pred_idx;
            ST_EDGE_WR_A: begin
                ram_we    = 1'b1;
                ram_addr  = pred_idx;
                ram_wdata = row_data | prey_bit;
            end
            ST_EDGE_RD_B: ram_addr = prey_idx;
            ST_EDGE_WR_B: begin
                ram_we    = 1'b1;
                ram_addr  = prey_idx;
                ram_wdata = row_data | pred_bit;
            end
            ST_Q_PICK:    ram_addr = pick_idx;
            ST_RESP:      out_load = out_free;
            default:      s_ready = 1'b0;
        endcase
    end

    // Datapath next values: graph state, traversal sets and the result.
    always_comb begin
        req_type_next     = req_type_reg;
        pred_next         = pred_reg;
        prey_next         = prey_reg;
        count_next        = count_reg;
        visited_next      = visited_reg;
        expanded_next     = expanded_reg;
        valid_next        = valid_reg;
        status_next       = status_reg;
        conn_next         = conn_reg;
        rd_valid_next     = valid_reg[ram_addr];
        m_status_next     = m_status_reg;
        m_connected_next  = m_connected_reg;
        m_node_count_next = m_node_count_reg;
        m_valid_next      = m_ready ? 1'b0 : m_valid_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_type_next = req_type_t'(s_req_type);
                    pred_next     = s_pred_node;
                    prey_next     = s_prey_node;
                    status_next   = 1'b0;
                    conn_next     = 1'b0;
                end
            end
            ST_CLEAR: begin
                valid_next   = '0;
                count_next   = '0;
                visited_next = '0;
            end
            ST_NODE: begin
                if (count_reg < COUNT_W'(MAX_NODES)) begin
                    count_next = count_reg + COUNT_W'(1);
                end else begin
                    status_next = 1'b1;
                end
            end
            ST_EDGE_RD_A: status_next = !edge_ok;
            ST_EDGE_WR_A: valid_next[pred_idx] = 1'b1;
            ST_EDGE_WR_B: valid_next[prey_idx] = 1'b1;
            ST_Q_INIT: begin
                visited_next  = (count_reg != '0) ? node_mask_t'(1) : '0;
                expanded_next = '0;
            end
            ST_Q_PICK:    expanded_next = expanded_reg | pick_oh;
            ST_Q_EXP:     visited_next  = visited_reg | row_data;
            ST_Q_FIN:     conn_next     = &(visited_reg | ~cnt_mask);
            default:      conn_next     = conn_reg;
        endcase

        // Result register load; it waits until the output slot is free or being taken.
        if (out_load) begin
            m_valid_next      = 1'b1;
            m_status_next     = status_reg;
            m_connected_next  = (req_type_reg == REQ_QUERY) && conn_reg;
            m_node_count_next = NODE_COUNT_W'(count_reg);
        end
    end

    // Control registers with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            visited_reg <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            visited_reg <= visited_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        req_type_reg     <= req_type_next;
        pred_reg         <= pred_next;
        prey_reg         <= prey_next;
        expanded_reg     <= expanded_next;
        rd_valid_reg     <= rd_valid_next;
        status_reg       <= status_next;
        conn_reg         <= conn_next;
        m_status_reg     <= m_status_next;
        m_connected_reg  <= m_connected_next;
        m_node_count_reg <= m_node_count_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_connected  = m_connected_reg;
    assign m_node_count = m_node_count_reg;

    // The node count never passes the store size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(MAX_NODES))
        else $error("node count exceeds the store size");

    // A clear leaves no valid row and no node behind.
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |=> (valid_reg == '0) && (count_reg == '0))
        else $error("clear left rows or nodes behind");

    // Only edge write states write the adjacency RAM.
    a_ram_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_EDGE_WR_A) || (state_reg == ST_EDGE_WR_B))
        else $error("adjacency RAM written outside an edge update");

    // Every expanded node has been reached during a traversal.
    a_expanded_in_visited: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_Q_PICK) || (state_reg == ST_Q_EXP))
            |-> ((expanded_reg & ~visited_reg) == '0))
        else $error("expanded node missing from the reached set");

    // A traversal never reaches a node outside the graph.
    a_visited_in_graph: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_Q_FIN) |-> ((visited_reg & ~cnt_mask) == '0))
        else $error("reached set holds a node beyond the count");

endmodule

`default_nettype wire
